// ===== src/rectangle_union_area_top_defines.svh =====
// Assertion macros used by the top-level RTL file.
`ifndef RECTANGLE_UNION_AREA_TOP_DEFINES_SVH
`define RECTANGLE_UNION_AREA_TOP_DEFINES_SVH

// Implication in the same cycle.
`define RUA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rua assertion failed");

// Implication in the following cycle.
`define RUA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rua assertion failed");

`endif

// ===== src/rua_pkg.sv =====
`timescale 1ns / 1ps

package rua_pkg;

  localparam int CW            = 15;
  localparam int AREA_W        = 31;
  localparam int COORD_SPAN_DEF = 32768;
  localparam int MAX_RECTS_DEF = 1024;
  localparam int RECT_W        = 4 * CW;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_RD,
    S_EVAL,
    S_ROW_RD,
    S_ROW_WR,
    S_MUL,
    S_ACC,
    S_DONE
  } state_t;

  typedef struct packed {
    logic clr;
    logic mul;
    logic acc;
  } mac_ctl_t;

endpackage

// ===== src/rectangle_union_area_top.sv =====
// Union area of axis-aligned rectangles.
// The in channel (in_valid/in_ready) takes one rectangle per transaction with
// x_left, y_bottom, x_right, y_top and last. Empty rectangles are dropped, and
// at most MAX_RECTS rectangles of a set are kept in an on-chip store.
// The transaction with last set starts a sweep: one pass over the store at x = 0
// and at each distinct edge x above it, with a read and an evaluation per stored
// rectangle, plus a row RAM read-modify-write per covered row of each edge at
// that x, and one multiply and accumulate between passes.
// The out channel (out_valid/out_ready) then gives the single area. The result
// sits in an output register; while the receiver stalls, the block still takes
// further rectangles and only holds a finished sweep until the register frees.
// After reset the coverage RAM is cleared, one row a cycle, over all COORD_SPAN
// rows; in_ready stays low meanwhile.
`timescale 1ns / 1ps

`include "rectangle_union_area_top_defines.svh"

module rectangle_union_area_top #(
  parameter int COORD_SPAN = rua_pkg::COORD_SPAN_DEF,
  parameter int MAX_RECTS  = rua_pkg::MAX_RECTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [rua_pkg::CW-1:0]       x_left,
  input  logic [rua_pkg::CW-1:0]       y_bottom,
  input  logic [rua_pkg::CW-1:0]       x_right,
  input  logic [rua_pkg::CW-1:0]       y_top,
  input  logic                         last,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [rua_pkg::AREA_W-1:0]   area
);

  localparam int CW   = rua_pkg::CW;
  localparam int IW   = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
  localparam int CNTW = $clog2(MAX_RECTS + 1);
  localparam int AW   = $clog2(COORD_SPAN);
  localparam int RW   = ((CW > AW) ? CW : AW) + 1;
  localparam int CRW  = $clog2(COORD_SPAN + 1);

  rua_pkg::state_t state, state_next;
  rua_pkg::mac_ctl_t mac_ctl;

  logic [RW-1:0]   clr_addr;
  logic [CNTW-1:0] count;
  logic [CNTW-1:0] idx;
  logic [CW-1:0]   cur_x;
  logic [CW-1:0]   nxt_x;
  logic            nxt_ok;
  logic [RW-1:0]   y;
  logic [RW-1:0]   y_end;
  logic            dir;
  logic [CRW-1:0]  covered_rows;

  logic                        in_acc;
  logic                        keep;
  logic [CNTW-1:0]             count_next;
  logic [CNTW-1:0]             idx_inc;
  logic                        pass_end;
  logic [rua_pkg::RECT_W-1:0]  rect_q;
  logic [CW-1:0]               q_xl, q_yb, q_xr, q_yt;
  logic [RW-1:0]               ybc, ytc;
  logic                        rise, fall, do_range;
  logic [CW-1:0]               cand_x;
  logic                        cand_ok;
  logic [CNTW-1:0]             row_q;
  logic [CNTW-1:0]             row_wdata;
  logic                        row_we;
  logic [AW-1:0]               row_waddr;
  logic [AW-1:0]               row_raddr;
  logic                        out_free;
  logic [rua_pkg::AREA_W-1:0]  acc;

  assign in_acc   = in_valid && in_ready;
  assign keep     = (x_right > x_left) && (y_top > y_bottom) &&
                    (count < CNTW'(MAX_RECTS));
  assign count_next = keep ? count + CNTW'(1) : count;
  assign idx_inc  = idx + CNTW'(1);
  assign pass_end = (idx_inc == count);
  assign out_free = !out_valid || out_ready;

  assign q_xl = rect_q[CW-1:0];
  assign q_yb = rect_q[2*CW-1:CW];
  assign q_xr = rect_q[3*CW-1:2*CW];
  assign q_yt = rect_q[4*CW-1:3*CW];

  always_comb begin
    ybc = (RW'(q_yb) > RW'(COORD_SPAN)) ? RW'(COORD_SPAN) : RW'(q_yb);
    ytc = (RW'(q_yt) > RW'(COORD_SPAN)) ? RW'(COORD_SPAN) : RW'(q_yt);
    rise = (q_xl == cur_x);
    fall = (q_xr == cur_x);
    do_range = (rise || fall) && (ybc < ytc);
    cand_x  = nxt_x;
    cand_ok = nxt_ok;
    if (q_xl > cur_x && (!cand_ok || q_xl < cand_x)) begin
      cand_x  = q_xl;
      cand_ok = 1'b1;
    end
    if (q_xr > cur_x && (!cand_ok || q_xr < cand_x)) begin
      cand_x  = q_xr;
      cand_ok = 1'b1;
    end
  end

  rua_ram #(
    .WIDTH (rua_pkg::RECT_W),
    .DEPTH (MAX_RECTS),
    .AW    (IW)
  ) u_rect_ram (
    .clk     (clk),
    .wr_en   (in_acc && keep),
    .wr_addr (count[IW-1:0]),
    .wr_data ({y_top, x_right, y_bottom, x_left}),
    .rd_addr (idx[IW-1:0]),
    .rd_data (rect_q)
  );

  always_comb begin
    if (state == rua_pkg::S_CLEAR) begin
      row_we    = 1'b1;
      row_waddr = clr_addr[AW-1:0];
      row_wdata = '0;
    end else begin
      row_we    = (state == rua_pkg::S_ROW_WR);
      row_waddr = y[AW-1:0];
      if (dir) begin
        row_wdata = row_q + CNTW'(1);
      end else if (row_q != '0) begin
        row_wdata = row_q - CNTW'(1);
      end else begin
        row_wdata = row_q;
      end
    end
  end

  assign row_raddr = y[AW-1:0];

  rua_ram #(
    .WIDTH (CNTW),
    .DEPTH (COORD_SPAN),
    .AW    (AW)
  ) u_row_ram (
    .clk     (clk),
    .wr_en   (row_we),
    .wr_addr (row_waddr),
    .wr_data (row_wdata),
    .rd_addr (row_raddr),
    .rd_data (row_q)
  );

  rua_mac #(
    .ROWS_W (CRW)
  ) u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctl  (mac_ctl),
    .dx   (nxt_x - cur_x),
    .rows (covered_rows),
    .acc  (acc)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      rua_pkg::S_CLEAR: begin
        if (clr_addr == RW'(COORD_SPAN - 1)) begin
          state_next = rua_pkg::S_IDLE;
        end
      end
      rua_pkg::S_IDLE: begin
        if (in_acc && last) begin
          state_next = (count_next == '0) ? rua_pkg::S_DONE : rua_pkg::S_RD;
        end
      end
      rua_pkg::S_RD: begin
        state_next = rua_pkg::S_EVAL;
      end
      rua_pkg::S_EVAL: begin
        if (do_range) begin
          state_next = rua_pkg::S_ROW_RD;
        end else if (!pass_end) begin
          state_next = rua_pkg::S_RD;
        end else begin
          state_next = cand_ok ? rua_pkg::S_MUL : rua_pkg::S_DONE;
        end
      end
      rua_pkg::S_ROW_RD: begin
        state_next = rua_pkg::S_ROW_WR;
      end
      rua_pkg::S_ROW_WR: begin
        if (y + RW'(1) != y_end) begin
          state_next = rua_pkg::S_ROW_RD;
        end else if (!pass_end) begin
          state_next = rua_pkg::S_RD;
        end else begin
          state_next = nxt_ok ? rua_pkg::S_MUL : rua_pkg::S_DONE;
        end
      end
      rua_pkg::S_MUL: begin
        state_next = rua_pkg::S_ACC;
      end
      rua_pkg::S_ACC: begin
        state_next = rua_pkg::S_RD;
      end
      rua_pkg::S_DONE: begin
        if (out_free) begin
          state_next = rua_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = rua_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    mac_ctl  = '0;
    unique case (state)
      rua_pkg::S_IDLE: begin
        in_ready    = 1'b1;
        mac_ctl.clr = in_valid && last;
      end
      rua_pkg::S_MUL: begin
        mac_ctl.mul = 1'b1;
      end
      rua_pkg::S_ACC: begin
        mac_ctl.acc = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rua_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr     <= '0;
      count        <= '0;
      idx          <= '0;
      cur_x        <= '0;
      nxt_x        <= '0;
      nxt_ok       <= 1'b0;
      covered_rows <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (state == rua_pkg::S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        rua_pkg::S_CLEAR: begin
          clr_addr <= clr_addr + RW'(1);
        end
        rua_pkg::S_IDLE: begin
          if (in_acc) begin
            count  <= count_next;
            idx    <= '0;
            cur_x  <= '0;
            nxt_ok <= 1'b0;
          end
        end
        rua_pkg::S_EVAL: begin
          nxt_x  <= cand_x;
          nxt_ok <= cand_ok;
          y      <= ybc;
          y_end  <= ytc;
          dir    <= rise;
          if (!do_range) begin
            idx <= idx_inc;
          end
        end
        rua_pkg::S_ROW_WR: begin
          y <= y + RW'(1);
          if (dir && row_q == '0) begin
            covered_rows <= covered_rows + CRW'(1);
          end else if (!dir && row_q == CNTW'(1)) begin
            covered_rows <= covered_rows - CRW'(1);
          end
          if (y + RW'(1) == y_end) begin
            idx <= idx_inc;
          end
        end
        rua_pkg::S_ACC: begin
          cur_x  <= nxt_x;
          nxt_ok <= 1'b0;
          idx    <= '0;
        end
        rua_pkg::S_DONE: begin
          if (out_free) begin
            count <= '0;
          end
        end
        default: begin
          count <= count;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == rua_pkg::S_DONE && out_free) begin
      area <= acc;
    end
  end

  `RUA_ASSERT_NOW(a_rows_bound, 1'b1, covered_rows <= CRW'(COORD_SPAN))
  `RUA_ASSERT_NOW(a_idle_uncovered, state == rua_pkg::S_IDLE, covered_rows == '0)
  `RUA_ASSERT_NOW(a_count_bound, 1'b1, count <= CNTW'(MAX_RECTS))
  `RUA_ASSERT_NEXT(a_last_starts, in_acc && last, !in_ready)

endmodule

// ===== src/rua_ram.sv =====
`timescale 1ns / 1ps

module rua_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== src/rua_mac.sv =====
`timescale 1ns / 1ps

module rua_mac #(
  parameter int ROWS_W = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  rua_pkg::mac_ctl_t        ctl,
  input  logic [rua_pkg::CW-1:0]   dx,
  input  logic [ROWS_W-1:0]        rows,
  output logic [rua_pkg::AREA_W-1:0] acc
);

  localparam int PW = rua_pkg::CW + ROWS_W;
  localparam int SW = PW + rua_pkg::AREA_W;

  logic [PW-1:0] prod;
  logic [SW-1:0] sum;

  assign sum = SW'(acc) + SW'(prod);

  always_ff @(posedge clk) begin
    if (ctl.mul) begin
      prod <= PW'(dx) * PW'(rows);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clr) begin
      acc <= '0;
    end else if (ctl.acc) begin
      acc <= sum[rua_pkg::AREA_W-1:0];
    end
  end

endmodule
